// File: sv/rgb_to_hsv_color_namer_macros.svh
// assertion macros for the rgb to hsv color namer
`ifndef RGB_TO_HSV_COLOR_NAMER_MACROS_SVH
`define RGB_TO_HSV_COLOR_NAMER_MACROS_SVH

// property that must hold at every edge outside reset
`define RHCN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define RHCN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rhcn_pkg.sv
// shared types and constants of the rgb to hsv color namer
package rhcn_pkg;

  // number of division cells: one quotient bit per cell
  localparam int unsigned QuoW  = 11;
  localparam int unsigned NumW  = 20;
  localparam int unsigned DenW  = 10;

  typedef enum logic [3:0] {
    CLS_BLACK     = 4'd0,
    CLS_WHITE     = 4'd1,
    CLS_GRAY      = 4'd2,
    CLS_RED       = 4'd3,
    CLS_YELLOW    = 4'd4,
    CLS_GREEN     = 4'd5,
    CLS_CYAN      = 4'd6,
    CLS_BLUE      = 4'd7,
    CLS_INDIGO    = 4'd8,
    CLS_ORANGE    = 4'd9,
    CLS_OLIVE     = 4'd10,
    CLS_TURQUOISE = 4'd11,
    CLS_LIGHTBLUE = 4'd12,
    CLS_PURPLE    = 4'd13
  } cls_e;

  // one pipeline token: two divisions in flight plus side data
  typedef struct packed {
    logic            vld;
    logic [NumW-1:0] hrem;
    logic [DenW-1:0] hden;
    logic [QuoW-1:0] hquo;
    logic [NumW-1:0] srem;
    logic [DenW-1:0] sden;
    logic [QuoW-1:0] squo;
    logic [6:0]      val;
  } tok_t;

endpackage

// File: sv/rhcn_cell.sv
// one restoring-division cell: resolves one quotient bit of both divisions
module rhcn_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [3:0]    bit_i,
  input  logic          en_i,
  input  rhcn_pkg::tok_t tok_i,
  output rhcn_pkg::tok_t tok_o
);
  import rhcn_pkg::*;

  logic [NumW:0] hsh, ssh;
  tok_t tok_d, tok_q;

  // compare against shifted divisor and subtract
  always_comb begin
    tok_d = tok_i;
    hsh = {1'b0, tok_i.hrem} - ({{(NumW+1-DenW){1'b0}}, tok_i.hden} << bit_i);
    ssh = {1'b0, tok_i.srem} - ({{(NumW+1-DenW){1'b0}}, tok_i.sden} << bit_i);
    if (!hsh[NumW]) begin
      tok_d.hrem = hsh[NumW-1:0];
      tok_d.hquo[bit_i] = 1'b1;
    end
    if (!ssh[NumW]) begin
      tok_d.srem = ssh[NumW-1:0];
      tok_d.squo[bit_i] = 1'b1;
    end
  end

  // token register, advances when the chain moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.vld <= 1'b0;
    end else if (en_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
endmodule

// File: sv/rgb_to_hsv_color_namer.sv
// rgb to hsv color namer: front end, chain of division cells, back end
// an input register, the division cells and an output register lie between input transfer and output valid
// throughput: one pixel per cycle; the whole chain moves while the output is free
// an output register stalls all cells together when the sink holds ready low
// reset clears all valid flags; payload registers are not reset
module rgb_to_hsv_color_namer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [8:0] hue_degrees_o,
  output logic [9:0] saturation_tenths_o,
  output logic [6:0] value_percent_o,
  output logic [3:0] color_class_o
);
  import rhcn_pkg::*;
  `include "rgb_to_hsv_color_namer_macros.svh"

  logic        adv;
  logic [7:0]  mx, mn, dd;
  logic [23:0] vprod;
  logic [NumW-1:0] hnum;
  tok_t        tok_d, tok_q;
  tok_t        chain [QuoW+1];

  // chain moves unless a finished result is stuck
  assign adv     = !valid_o || ready_i;
  assign ready_o = adv;

  // max, min and numerators of both divisions
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dd = mx - mn;
    if (mx == red_i) begin
      hnum = NumW'(360 * dd) + NumW'(60 * green_i) - NumW'(60 * blue_i);
    end else if (mx == green_i) begin
      hnum = NumW'(120 * dd) + NumW'(60 * blue_i) - NumW'(60 * red_i);
    end else begin
      hnum = NumW'(240 * dd) + NumW'(60 * red_i) - NumW'(60 * green_i);
    end
    // floor of x over 255 as ((x + 1) * 257) >> 16, exact for x below 65535
    vprod = ({16'd0, mx} * 24'd100 + 24'd1) * 24'd257;
    tok_d.vld  = valid_i;
    tok_d.hrem = (dd == 8'd0) ? '0 : hnum;
    tok_d.hden = (dd == 8'd0) ? DenW'(1) : {2'b00, dd};
    tok_d.hquo = '0;
    tok_d.srem = (mx == 8'd0) ? '0 : NumW'(2000 * dd) + NumW'(mx);
    tok_d.sden = (mx == 8'd0) ? DenW'(1) : {1'b0, mx, 1'b0};
    tok_d.squo = '0;
    tok_d.val  = vprod[22:16];
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.vld <= 1'b0;
    end else if (adv) begin
      tok_q <= tok_d;
    end
  end

  assign chain[0] = tok_q;

  // row of division cells, most significant quotient bit first
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    rhcn_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .bit_i (4'(QuoW - 1 - i)),
      .en_i  (adv),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  // hue wrap and color naming
  logic [8:0] hue;
  logic [9:0] sat;
  logic [2:0] sect;
  logic       exact;
  cls_e       cls;
  tok_t       last;
  assign last = chain[QuoW];
  always_comb begin
    hue = (last.hquo >= 11'd360) ? 9'(last.hquo - 11'd360) : last.hquo[8:0];
    sat = last.squo[9:0];
    // 60-degree sector by comparison
    if (hue >= 9'd300) sect = 3'd5;
    else if (hue >= 9'd240) sect = 3'd4;
    else if (hue >= 9'd180) sect = 3'd3;
    else if (hue >= 9'd120) sect = 3'd2;
    else if (hue >= 9'd60) sect = 3'd1;
    else sect = 3'd0;
    exact = (10'(sect) * 10'd60) == {1'b0, hue};
    if (sat == 10'd0) begin
      if (last.val == 7'd0) cls = CLS_BLACK;
      else if (last.val == 7'd100) cls = CLS_WHITE;
      else cls = CLS_GRAY;
    end else begin
      unique case (sect)
        3'd0: cls = exact ? CLS_RED    : CLS_ORANGE;
        3'd1: cls = exact ? CLS_YELLOW : CLS_OLIVE;
        3'd2: cls = exact ? CLS_GREEN  : CLS_TURQUOISE;
        3'd3: cls = exact ? CLS_CYAN   : CLS_LIGHTBLUE;
        3'd4: cls = exact ? CLS_BLUE   : CLS_INDIGO;
        default: cls = exact ? CLS_INDIGO : CLS_PURPLE;
      endcase
    end
  end

  // output register
  logic       vld_q;
  logic [8:0] hue_q;
  logic [9:0] sat_q;
  logic [6:0] val_q;
  logic [3:0] cls_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= last.vld;
      hue_q <= hue;
      sat_q <= sat;
      val_q <= last.val;
      cls_q <= 4'(cls);
    end
  end

  assign valid_o             = vld_q;
  assign hue_degrees_o       = hue_q;
  assign saturation_tenths_o = sat_q;
  assign value_percent_o     = val_q;
  assign color_class_o       = cls_q;

  // checks
  `RHCN_ASSERT(a_hue_range, !valid_o || hue_degrees_o < 9'd360, "hue out of range")
  `RHCN_ASSERT(a_sat_range, !valid_o || saturation_tenths_o <= 10'd1000, "sat out of range")
  `RHCN_ASSERT_NEXT(a_hold, valid_o && !ready_i, valid_o && $stable(hue_degrees_o), "stall lost")
endmodule

// File: tb/rgb_to_hsv_color_namer_test.sv
// testbench for the rgb to hsv color namer: directed and random pixel stream checked against a predictor
`timescale 1ns / 1ps

module rgb_to_hsv_color_namer_test;
  import rhcn_pkg::*;

  // one converted pixel
  typedef struct packed {
    logic [8:0] hue;
    logic [9:0] sat;
    logic [6:0] val;
    logic [3:0] cls;
  } hsv_t;

  // predicted conversion of one pixel
  function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsv_t o;
    int unsigned mx, mn, d, num, hq;
    cls_e c;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) hq = 0;
    else begin
      if (mx == r) num = 360 * d + 60 * g - 60 * b;
      else if (mx == g) num = 120 * d + 60 * b - 60 * r;
      else num = 240 * d + 60 * r - 60 * g;
      hq = (num / d) % 360;
    end
    o.hue = 9'(hq);
    o.sat = (mx == 0) ? 10'd0 : 10'((2000 * d + mx) / (2 * mx));
    o.val = 7'((100 * mx) / 255);
    if (o.sat == 0) begin
      if (o.val == 0) c = CLS_BLACK;
      else if (o.val == 100) c = CLS_WHITE;
      else c = CLS_GRAY;
    end else if (hq % 60 == 0) begin
      case (hq / 60)
        0: c = CLS_RED;
        1: c = CLS_YELLOW;
        2: c = CLS_GREEN;
        3: c = CLS_CYAN;
        4: c = CLS_BLUE;
        default: c = CLS_INDIGO;
      endcase
    end else begin
      case (hq / 60)
        0: c = CLS_ORANGE;
        1: c = CLS_OLIVE;
        2: c = CLS_TURQUOISE;
        3: c = CLS_LIGHTBLUE;
        4: c = CLS_INDIGO;
        default: c = CLS_PURPLE;
      endcase
    end
    o.cls = c;
    return o;
  endfunction

  // queue of pending conversions and mismatch bookkeeping
  class hsv_scoreboard;
    hsv_t pending[$];
    int errors;
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pending.push_back(convert_pixel(r, g, b));
    endfunction
    function void check_result(hsv_t got);
      hsv_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hue %0d", got.hue);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp h%0d s%0d v%0d c%0d got h%0d s%0d v%0d c%0d",
                   e.hue, e.sat, e.val, e.cls, got.hue, got.sat, got.val, got.cls);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic valid_i = 0, ready_i = 0;
  logic [7:0] red_i = 0, green_i = 0, blue_i = 0;
  logic ready_o, valid_o;
  logic [8:0] hue_degrees_o;
  logic [9:0] saturation_tenths_o;
  logic [6:0] value_percent_o;
  logic [3:0] color_class_o;
  hsv_scoreboard sb;
  int cycles = 0;
  bit hold_sink = 0;

  rgb_to_hsv_color_namer uut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // random gap length: mostly short, a few long
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // offer one pixel and wait for its transfer
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    valid_i <= 1; red_i <= r; green_i <= g; blue_i <= b;
    do @(posedge clk_i); while (!ready_o);
    sb.note_pixel(r, g, b);
  endtask

  // pause the sender between pixels, valid dropped
  task automatic idle_sender(int n);
    if (n > 0) begin
      valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // channel value biased toward extremes
  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: random ready, long hold while hold_sink is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && ready_i)
        sb.check_result('{hue_degrees_o, saturation_tenths_o, value_percent_o, color_class_o});
      if (hold_sink) ready_i <= 0;
      else if ($urandom_range(0, 3) == 0) ready_i <= ($urandom_range(0, 9) == 0) ? 0 : 1;
      else ready_i <= ($urandom_range(0, 4) != 0);
    end
  end

  // long receiver hold counted in cycles
  initial begin
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    hold_sink = 1;
    repeat (200) @(posedge clk_i);
    hold_sink = 0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 200000) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [7:0] dir [25][3];
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: black, white, gray, primaries, ties, red wrap, bands
    dir = '{'{0,0,0}, '{255,255,255}, '{128,128,128}, '{1,1,1}, '{254,254,254},
            '{255,0,0}, '{255,255,0}, '{0,255,0}, '{0,255,255}, '{0,0,255},
            '{255,0,255}, '{255,0,1}, '{255,128,0}, '{128,255,0}, '{0,255,128},
            '{0,128,255}, '{128,0,255}, '{200,100,200}, '{3,2,2}, '{255,254,254},
            '{1,0,0}, '{170,85,255}, '{7,7,0}, '{10,0,3}, '{255,1,0}};
    foreach (dir[i]) begin
      send_pixel(dir[i][0], dir[i][1], dir[i][2]);
      idle_sender(gap_len());
    end
    for (int i = 0; i < 900; i++) begin
      if (i == 500) begin
        valid_i <= 0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      if (i % 3 == 0)
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      else
        send_pixel(pick_chan(), pick_chan(), pick_chan());
      if (i < 250 || i > 600 || $urandom_range(0, 1)) idle_sender(gap_len());
    end
    valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/rhcn_pkg.sv
sv/rhcn_cell.sv
sv/rgb_to_hsv_color_namer.sv
tb/rgb_to_hsv_color_namer_test.sv
